FILE: sv/bpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types and constants of the BMP pixel row to RGB decoder.
// ----------------------------------------------------------------------------
package bpr_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;

    // Largest effective image height.
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    // Request kinds carried on the slave tuser bit.
    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    // Pixel depth codes.
    localparam logic [1:0] MODE_IDX4  = 2'd0;
    localparam logic [1:0] MODE_IDX8  = 2'd1;
    localparam logic [1:0] MODE_RGB16 = 2'd2;
    localparam logic [1:0] MODE_BGR24 = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEPTH_MODE = 2'd0;
    localparam logic [1:0] REG_GREEN_SIX  = 2'd1;
    localparam logic [1:0] REG_WIDTH      = 2'd2;
    localparam logic [1:0] REG_HEIGHT     = 2'd3;

    // Configuration register values.
    typedef struct packed {
        logic [1:0]  depth_mode;
        logic        green_six_bits;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } bpr_cfg_t;

    // One decoded data byte: up to two pixels waiting for palette data.
    typedef struct packed {
        logic        two;      // a second pixel follows the first
        logic        p1_pal;   // first pixel color comes from palette port A
        logic [23:0] rgb;      // direct color of the first pixel, red on top
        logic [11:0] col1;
        logic [11:0] col2;
        logic [11:0] row;
        logic        done1;
        logic        done2;
    } bpr_item_t;

endpackage
`default_nettype wire

FILE: sv/bpr_palette.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpr_palette
// Color palette memory with one write port and two registered read ports.
// Entries never written read as black.
// ----------------------------------------------------------------------------
module bpr_palette #(
    parameter int PALETTE_DEPTH = bpr_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [7:0]  wr_addr,
    input  logic [23:0] wr_data,
    input  logic        rd_en,
    input  logic [7:0]  rd_addr_a,
    input  logic [7:0]  rd_addr_b,
    output logic [23:0] rd_data_a,
    output logic [23:0] rd_data_b
);
    import bpr_pkg::*;

    localparam int PAW = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

    logic [23:0]              mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] valid_reg;
    logic [23:0]              data_a_reg;
    logic [23:0]              data_b_reg;
    logic                     ok_a_reg;
    logic                     ok_b_reg;
    logic                     wr_in_range;
    logic                     a_in_range;
    logic                     b_in_range;

    assign wr_in_range = {1'b0, wr_addr} < DEPTH9;
    assign a_in_range  = {1'b0, rd_addr_a} < DEPTH9;
    assign b_in_range  = {1'b0, rd_addr_b} < DEPTH9;

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem[wr_addr[PAW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            data_a_reg <= mem[rd_addr_a[PAW-1:0]];
            data_b_reg <= mem[rd_addr_b[PAW-1:0]];
        end
    end

    // Valid bits stand in for clearing the memory at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ok_a_reg  <= 1'b0;
            ok_b_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_in_range)
            begin
                valid_reg[wr_addr[PAW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                ok_a_reg <= a_in_range && valid_reg[rd_addr_a[PAW-1:0]];
                ok_b_reg <= b_in_range && valid_reg[rd_addr_b[PAW-1:0]];
            end
        end
    end

    assign rd_data_a = ok_a_reg ? data_a_reg : 24'd0;
    assign rd_data_b = ok_b_reg ? data_b_reg : 24'd0;

endmodule
`default_nettype wire

FILE: sv/bpr_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpr_decode
// Row and pixel bookkeeping: assembles multi-byte pixels, skips row padding,
// and tags each pixel with its column, display row and end-of-image flag.
// ----------------------------------------------------------------------------
module bpr_decode #(
    parameter int MAX_WIDTH = bpr_pkg::MAX_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bpr_pkg::bpr_cfg_t   cfg,
    input  logic                accept,
    input  logic                operation,
    input  logic [7:0]          data_byte,
    output logic                item_valid,
    output bpr_pkg::bpr_item_t  item
);
    import bpr_pkg::*;

    // The width register holds at most 8191.
    localparam int WMAX = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
    localparam int CW   = $clog2(WMAX + 1);
    localparam int BW   = $clog2(3 * WMAX + 4);
    localparam logic [12:0] WMAX13 = 13'(WMAX);

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    logic [15:0]   partial_reg, partial_next;
    logic [1:0]    phase_reg, phase_next;
    logic [BW-1:0] bir_reg, bir_next;
    logic [CW-1:0] col_reg, col_next;
    logic [12:0]   row_reg, row_next;

    logic [CW-1:0] w_eff;
    logic [CW:0]   w_wide;
    logic [CW:0]   col_p1;
    logic [12:0]   h_eff;
    logic [BW-1:0] w_ext;
    logic [BW-1:0] linesize;
    logic [BW-1:0] pitch;
    logic [BW-1:0] bir_inc;
    logic          active;
    logic          in_data;
    logic          row_end;
    logic          last_row;
    logic          e1;
    logic          e2;
    logic          emit1;
    logic          emit2;
    logic [15:0]   p16;
    logic [23:0]   rgb16;
    logic [23:0]   rgb24;
    logic [23:0]   rgb;

    always_comb
    begin
        if (cfg.image_width == 13'd0)
        begin
            w_eff = CW'(1);
        end
        else if (cfg.image_width > WMAX13)
        begin
            w_eff = CW'(WMAX);
        end
        else
        begin
            w_eff = CW'(cfg.image_width);
        end

        if (cfg.image_height == 13'd0)
        begin
            h_eff = 13'd1;
        end
        else if (cfg.image_height > MAX_HEIGHT)
        begin
            h_eff = MAX_HEIGHT;
        end
        else
        begin
            h_eff = cfg.image_height;
        end
    end

    assign w_ext  = BW'(w_eff);
    assign w_wide = {1'b0, w_eff};
    assign col_p1 = {1'b0, col_reg} + 1'b1;

    always_comb
    begin
        case (cfg.depth_mode)
            MODE_IDX4:  linesize = (w_ext + 1'b1) >> 1;
            MODE_IDX8:  linesize = w_ext;
            MODE_RGB16: linesize = w_ext << 1;
            default:    linesize = (w_ext << 1) + w_ext;
        endcase
    end

    assign pitch   = (linesize + BW'(3)) & ~BW'(3);
    assign bir_inc = bir_reg + 1'b1;
    assign row_end = bir_inc >= pitch;
    assign in_data = bir_reg < linesize;
    assign active  = accept && (operation == OP_PIXEL) && (row_reg < h_eff);
    assign last_row = row_reg == (h_eff - 13'd1);

    // A pixel is kept only while its column is inside the row.
    assign e1 = col_reg < w_eff;
    assign e2 = e1 && (col_p1 < w_wide);

    // 16-bit pixels are little-endian; 5-bit fields scale by 8, 6-bit by 4.
    assign p16 = {data_byte, partial_reg[7:0]};
    always_comb
    begin
        if (cfg.green_six_bits)
        begin
            rgb16 = {p16[15:11], 3'd0, p16[10:5], 2'd0, p16[4:0], 3'd0};
        end
        else
        begin
            rgb16 = {p16[14:10], 3'd0, p16[9:5], 3'd0, p16[4:0], 3'd0};
        end
    end
    assign rgb24 = {data_byte, partial_reg[15:8], partial_reg[7:0]};

    always_comb
    begin
        partial_next = partial_reg;
        phase_next   = phase_reg;
        bir_next     = bir_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        emit1        = 1'b0;
        emit2        = 1'b0;
        rgb          = rgb24;
        if (active)
        begin
            if (in_data)
            begin
                case (cfg.depth_mode)
                    MODE_IDX4:
                    begin
                        emit1 = e1;
                        emit2 = e2;
                    end
                    MODE_IDX8:
                    begin
                        emit1 = e1;
                    end
                    MODE_RGB16:
                    begin
                        if (phase_reg == PH_FIRST)
                        begin
                            partial_next = {8'd0, data_byte};
                            phase_next   = PH_SECOND;
                        end
                        else
                        begin
                            emit1      = e1;
                            rgb        = rgb16;
                            phase_next = PH_FIRST;
                        end
                    end
                    default:
                    begin
                        if (phase_reg == PH_FIRST)
                        begin
                            partial_next = {8'd0, data_byte};
                            phase_next   = PH_SECOND;
                        end
                        else if (phase_reg == PH_SECOND)
                        begin
                            partial_next = {data_byte, partial_reg[7:0]};
                            phase_next   = PH_THIRD;
                        end
                        else
                        begin
                            emit1      = e1;
                            phase_next = PH_FIRST;
                        end
                    end
                endcase
            end
            col_next = col_reg + CW'(emit1) + CW'(emit2);
            if (row_end)
            begin
                bir_next   = '0;
                col_next   = '0;
                phase_next = PH_FIRST;
                row_next   = row_reg + 13'd1;
            end
            else
            begin
                bir_next = bir_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 16'd0;
            phase_reg   <= PH_FIRST;
            bir_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= 13'd0;
        end
        else
        begin
            partial_reg <= partial_next;
            phase_reg   <= phase_next;
            bir_reg     <= bir_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    assign item_valid = emit1;

    always_comb
    begin
        item.two    = emit2;
        item.p1_pal = !cfg.depth_mode[1];
        item.rgb    = rgb;
        item.col1   = 12'(col_reg);
        item.col2   = 12'(col_p1);
        item.row    = 12'(h_eff - 13'd1 - row_reg);
        item.done1  = last_row && ({1'b0, col_reg} == (w_wide - 1'b1));
        item.done2  = last_row && (col_p1 == (w_wide - 1'b1));
    end

    // The row counter only moves on an accepted data byte.
    a_row_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(row_reg) |-> $past(accept && (operation == OP_PIXEL)))
        else $error("row counter moved without a data byte");

    // A second pixel never appears without the first.
    a_two_needs_one: assert property (@(posedge clk) disable iff (!rst_n)
        emit2 |-> emit1 && (cfg.depth_mode == MODE_IDX4))
        else $error("second pixel without first pixel");

endmodule
`default_nettype wire

FILE: sv/bpr_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpr_out
// Holds one decoded byte next to its palette data and hands its one or two
// pixels to the output register, one per cycle while the output is free.
// ----------------------------------------------------------------------------
module bpr_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  bpr_pkg::bpr_item_t item,
    input  logic [23:0]        rgb_a,
    input  logic [23:0]        rgb_b,
    output logic               in_ready,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [47:0]        m_axis_tdata,  // red, green, blue, column, display_row
    output logic               m_axis_tlast,
    output logic [0:0]         m_axis_tuser   // image_done
);
    import bpr_pkg::*;

    bpr_item_t   s1_item_reg;
    logic        s1_valid_reg, s1_valid_next;
    logic        second_reg, second_next;
    logic        tvalid_reg, tvalid_next;
    logic [47:0] tdata_reg;
    logic        tlast_reg;
    logic        tuser_reg;

    logic        out_free;
    logic        move;
    logic        s1_last;
    logic [23:0] pix_rgb;
    logic [11:0] pix_col;
    logic        pix_done;

    assign out_free = !tvalid_reg || m_axis_tready;
    assign move     = s1_valid_reg && out_free;
    assign s1_last  = !s1_item_reg.two || second_reg;
    assign in_ready = !s1_valid_reg || (out_free && s1_last);

    always_comb
    begin
        if (second_reg)
        begin
            pix_rgb  = rgb_b;
            pix_col  = s1_item_reg.col2;
            pix_done = s1_item_reg.done2;
        end
        else
        begin
            pix_rgb  = s1_item_reg.p1_pal ? rgb_a : s1_item_reg.rgb;
            pix_col  = s1_item_reg.col1;
            pix_done = s1_item_reg.done1;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        second_next   = second_reg;
        if (item_valid)
        begin
            s1_valid_next = 1'b1;
            second_next   = 1'b0;
        end
        else if (move && s1_last)
        begin
            s1_valid_next = 1'b0;
            second_next   = 1'b0;
        end
        else if (move)
        begin
            second_next = 1'b1;
        end

        if (move)
        begin
            tvalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            tvalid_next = 1'b0;
        end
        else
        begin
            tvalid_next = tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            second_reg   <= 1'b0;
            tvalid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            second_reg   <= second_next;
            tvalid_reg   <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid)
        begin
            s1_item_reg <= item;
        end
        if (move)
        begin
            tdata_reg <= {s1_item_reg.row, pix_col, pix_rgb[7:0], pix_rgb[15:8],
                          pix_rgb[23:16]};
            tlast_reg <= s1_last;
            tuser_reg <= pix_done;
        end
    end

    assign m_axis_tvalid   = tvalid_reg;
    assign m_axis_tdata    = tdata_reg;
    assign m_axis_tlast    = tlast_reg;
    assign m_axis_tuser[0] = tuser_reg;

    // The final pixel of the image is always the last one of its byte.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        tvalid_reg && tuser_reg |-> tlast_reg)
        else $error("image done flagged on a pixel that is not last");

    // The second half is only ever reached for a two-pixel byte.
    a_second_two: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && second_reg |-> s1_item_reg.two)
        else $error("second pixel stage on a one-pixel byte");

    // Moving the first of two pixels leaves the second in place.
    a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
        move && !s1_last |=> s1_valid_reg && second_reg)
        else $error("second pixel lost");

endmodule
`default_nettype wire

FILE: sv/bmp_pixel_row_to_rgb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_pixel_row_to_rgb
// Uncompressed BMP pixel byte stream to RGB888 pixel stream.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while s_axis_tready is high: a palette
// write or a raw data byte in file order. A data byte gives zero, one or two
// pixels. Unless the output stalls, the output register sends one pixel per
// cycle and 8-bit, 16-bit and 24-bit modes sustain one byte per cycle; in
// 4-bit mode a two-pixel byte holds off the next byte until its second pixel
// moves to the single output register. The palette is a 1-write, 2-read
// memory with per-entry valid bits, so it reads as black after reset with no
// clearing pass. The user must make configuration writes only while the block
// is idle; the block does not enforce it. After the last row of the image
// further data bytes are ignored until reset or a larger height is set.
// ----------------------------------------------------------------------------
module bmp_pixel_row_to_rgb #(
    parameter int MAX_WIDTH     = bpr_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_DEPTH = bpr_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte, palette_index, palette_red, palette_green, palette_blue
    input  logic [39:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red_out, green_out, blue_out, column, display_row
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,  // last_of_run
    output logic [0:0]  m_axis_tuser   // image_done
);
    import bpr_pkg::*;

    bpr_cfg_t   cfg_reg;
    bpr_item_t  item;
    logic       item_valid;
    logic       accept;
    logic       operation;
    logic [7:0] data_byte;
    logic [7:0] rd_addr_a;
    logic [23:0] rgb_a;
    logic [23:0] rgb_b;
    logic       in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_mode     <= MODE_BGR24;
            cfg_reg.green_six_bits <= 1'b0;
            cfg_reg.image_width    <= 13'd1;
            cfg_reg.image_height   <= 13'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEPTH_MODE: cfg_reg.depth_mode     <= cfg_data[1:0];
                REG_GREEN_SIX:  cfg_reg.green_six_bits <= cfg_data[0];
                REG_WIDTH:      cfg_reg.image_width    <= cfg_data;
                REG_HEIGHT:     cfg_reg.image_height   <= cfg_data;
                default:        cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign s_axis_tready = in_ready;
    assign accept        = s_axis_tvalid && in_ready;
    assign operation     = s_axis_tuser[0];
    assign data_byte     = s_axis_tdata[7:0];

    // In 4-bit mode port A reads the high nibble and port B the low nibble.
    assign rd_addr_a = (cfg_reg.depth_mode == MODE_IDX4) ? {4'd0, data_byte[7:4]} : data_byte;

    bpr_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept && (operation == OP_PALETTE)),
        .wr_addr   (s_axis_tdata[15:8]),
        .wr_data   (s_axis_tdata[39:16] == 24'd0 ? 24'd0 :
                    {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
        .rd_en     (accept && (operation == OP_PIXEL)),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b ({4'd0, data_byte[3:0]}),
        .rd_data_a (rgb_a),
        .rd_data_b (rgb_b)
    );

    bpr_decode #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (accept),
        .operation  (operation),
        .data_byte  (data_byte),
        .item_valid (item_valid),
        .item       (item)
    );

    bpr_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .rgb_a         (rgb_a),
        .rgb_b         (rgb_b),
        .in_ready      (in_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the BMP pixel row to RGB decoder.
// ----------------------------------------------------------------------------
// Palette writes and raw data bytes are sent on the request stream. Every
// accepted request is run through a predictor that keeps its own palette,
// byte assembly and row position, and the pixels it works out wait in a queue.
// Each pixel taken from the output stream is checked against the oldest one.
// A few directed requests cover the reset settings, every pixel depth and the
// range edges. Random phases follow, with new settings between them. Each
// phase sends whole padded rows, sometimes with a broken row tail, and
// sometimes ends the image. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import bpr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STREAM_GOAL    = 1650;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] display_row;
        logic        last_of_run;
        logic        image_done;
    } pixel_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [1:0]  cfg_index     = REG_DEPTH_MODE;
    logic [12:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = OP_PALETTE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;

    int idle_pct     = 16;
    int error_count  = 0;
    int live_items   = 0;
    int quiet_cycles = 0;

    // Predictor copy of the registers and of the decoder state.
    logic [1:0]  cur_mode   = MODE_BGR24;
    logic        cur_green6 = 1'b0;
    logic [12:0] cur_width  = 13'd1;
    logic [12:0] cur_height = 13'd1;
    logic [23:0] pal_rgb [PALETTE_DEPTH_DEF];
    logic [15:0] held_bytes = '0;
    logic [1:0]  byte_slot  = '0;
    int unsigned row_byte   = 0;
    int unsigned col_pos    = 0;
    int unsigned rows_done  = 0;
    int unsigned run_len    = 0;

    pixel_t expected_pixels [$];

    bmp_pixel_row_to_rgb dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input logic [12:0] v, input int unsigned top);
        if (v == 13'd0)
            return 1;
        if (v > top)
            return top;
        return 32'(v);
    endfunction

    function automatic int unsigned line_len(input logic [1:0] mode, input int unsigned w);
        case (mode)
            MODE_IDX4:  return (w + 1) / 2;
            MODE_IDX8:  return w;
            MODE_RGB16: return 2 * w;
            default:    return 3 * w;
        endcase
    endfunction

    function automatic string pixel_str(input pixel_t p);
        return $sformatf("rgb=%02h_%02h_%02h col=%0d row=%0d last=%0b done=%0b",
                         p.red, p.green, p.blue, p.column, p.display_row,
                         p.last_of_run, p.image_done);
    endfunction

    // A pixel past the current width is dropped.
    function automatic void add_pixel(input logic [23:0] rgb, input int unsigned w,
                                      input int unsigned h);
        pixel_t px;
        if (col_pos >= w)
            return;
        px.red         = rgb[23:16];
        px.green       = rgb[15:8];
        px.blue        = rgb[7:0];
        px.column      = col_pos[11:0];
        px.display_row = 12'(h - 1 - rows_done);
        px.last_of_run = 1'b0;
        px.image_done  = (rows_done == h - 1) && (col_pos == w - 1);
        expected_pixels.push_back(px);
        col_pos++;
        run_len++;
    endfunction

    function automatic void decode_request(input logic op, input logic [7:0] d,
                                           input logic [7:0] idx, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b);
        int unsigned w;
        int unsigned h;
        int unsigned line_bytes;
        int unsigned pitch;
        logic [15:0] word;
        pixel_t      tail;
        w = clamp_dim(cur_width, MAX_WIDTH_DEF);
        h = clamp_dim(cur_height, int'(MAX_HEIGHT));
        run_len = 0;
        if (op == OP_PALETTE)
        begin
            pal_rgb[idx] = {r, g, b};
            live_items++;
            return;
        end
        // Once the last row has passed, data bytes are dropped.
        if (rows_done >= h)
            return;
        live_items++;
        line_bytes = line_len(cur_mode, w);
        pitch = (line_bytes + 3) & ~32'd3;
        if (row_byte < line_bytes)
        begin
            case (cur_mode)
                MODE_IDX4:
                begin
                    add_pixel(pal_rgb[{4'd0, d[7:4]}], w, h);
                    add_pixel(pal_rgb[{4'd0, d[3:0]}], w, h);
                end
                MODE_IDX8:
                    add_pixel(pal_rgb[d], w, h);
                MODE_RGB16:
                    if (byte_slot == 2'd0)
                    begin
                        held_bytes = {8'd0, d};
                        byte_slot = 2'd1;
                    end
                    else
                    begin
                        word = {d, held_bytes[7:0]};
                        if (cur_green6)
                            add_pixel({word[15:11], 3'd0, word[10:5], 2'd0, word[4:0], 3'd0},
                                      w, h);
                        else
                            add_pixel({word[14:10], 3'd0, word[9:5], 3'd0, word[4:0], 3'd0},
                                      w, h);
                        byte_slot = 2'd0;
                    end
                default:
                    if (byte_slot == 2'd0)
                    begin
                        held_bytes = {8'd0, d};
                        byte_slot = 2'd1;
                    end
                    else if (byte_slot == 2'd1)
                    begin
                        held_bytes = {d, held_bytes[7:0]};
                        byte_slot = 2'd2;
                    end
                    else
                    begin
                        // File order is blue, green, red.
                        add_pixel({d, held_bytes}, w, h);
                        byte_slot = 2'd0;
                    end
            endcase
        end
        row_byte++;
        if (row_byte >= pitch)
        begin
            row_byte = 0;
            col_pos = 0;
            byte_slot = 2'd0;
            rows_done++;
        end
        if (run_len > 0)
        begin
            tail = expected_pixels.pop_back();
            tail.last_of_run = 1'b1;
            expected_pixels.push_back(tail);
        end
    endfunction

    // Output check first, then the request taken at the same edge.
    always @(posedge clk)
    begin : result_check
        pixel_t got;
        pixel_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.red         = m_axis_tdata[7:0];
                got.green       = m_axis_tdata[15:8];
                got.blue        = m_axis_tdata[23:16];
                got.column      = m_axis_tdata[35:24];
                got.display_row = m_axis_tdata[47:36];
                got.last_of_run = m_axis_tlast;
                got.image_done  = m_axis_tuser[0];
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    $display("%0t: pixel with none expected, got %s", $time, pixel_str(got));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        $display("%0t: pixel mismatch, expected %s, got %s", $time,
                                 pixel_str(want), pixel_str(got));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_request(s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[15:8],
                               s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= idle_pct);

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_req(input logic op, input logic [39:0] payload);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= payload;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] d);
        send_req(OP_PIXEL, {32'($urandom), d});
    endtask

    task automatic send_palette(input logic [7:0] idx, input logic [23:0] rgb);
        send_req(OP_PALETTE, {rgb[7:0], rgb[15:8], rgb[23:16], idx, 8'($urandom)});
    endtask

    // Hold off new requests until every predicted pixel has come out.
    task automatic drain(input int settle);
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // The request stream is held idle while the registers are written.
    task automatic set_config(input logic [1:0] mode, input logic g6,
                              input logic [12:0] w, input logic [12:0] h);
        s_axis_tvalid <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DEPTH_MODE;
        cfg_data  <= {11'd0, mode};
        @(negedge clk);
        cfg_index <= REG_GREEN_SIX;
        cfg_data  <= {12'd0, g6};
        @(negedge clk);
        cfg_index <= REG_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_wr_en  <= 1'b0;
        cur_mode   = mode;
        cur_green6 = g6;
        cur_width  = w;
        cur_height = h;
    endtask

    // Reset settings: one 24-bit pixel ends a one-row image, later bytes are dropped.
    task automatic test_reset_state();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h5A);
        send_byte(8'h3C);
        send_byte(8'hC3);
        drain(DRAIN_CYCLES);
    endtask

    // Odd width in 4-bit mode drops the last low nibble; width 0 acts as 1.
    task automatic test_indexed_modes();
        send_palette(8'd0, 24'hFFFFFF);
        send_palette(8'd15, 24'h123456);
        send_palette(8'd255, 24'hA5C30F);
        set_config(MODE_IDX4, 1'b0, 13'd3, 13'h1FFF);
        send_byte(8'h2F);
        send_byte(8'hF7);
        send_byte(8'h00);
        send_byte(8'hFF);
        drain(DRAIN_CYCLES);
        set_config(MODE_IDX8, 1'b1, 13'd0, 13'h1FFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        drain(DRAIN_CYCLES);
    endtask

    task automatic test_direct_modes();
        set_config(MODE_RGB16, 1'b0, 13'd2, 13'h1FFF);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h80);
        drain(DRAIN_CYCLES);
        set_config(MODE_RGB16, 1'b1, 13'd1, 13'h1FFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        drain(DRAIN_CYCLES);
    endtask

    // Widest setting, left mid-row so that the next settings end the row early.
    task automatic test_wide_row();
        set_config(MODE_IDX4, 1'b0, 13'h1FFF, 13'd4096);
        repeat (400) send_byte(8'($urandom));
        drain(DRAIN_CYCLES);
    endtask

    // One set of random settings followed by whole rows of random content.
    task automatic random_phase();
        logic [1:0]  mode;
        logic        g6;
        logic [12:0] w;
        logic [12:0] h;
        int unsigned pick;
        int unsigned pitch;
        int unsigned count;
        mode = 2'($urandom_range(3));
        g6   = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 75)
            w = 13'($urandom_range(9, 1));
        else if (pick < 85)
            w = 13'd0;
        else
            w = 13'($urandom_range(48, 10));
        pick = $urandom_range(99);
        if (pick < 10)
            h = 13'(rows_done + 1);
        else if (pick < 15)
            h = 13'd0;
        else if (pick < 55)
            h = 13'h1FFF;
        else
            h = 13'($urandom_range(4096, rows_done + 50));
        set_config(mode, g6, w, h);
        pitch = (line_len(mode, clamp_dim(w, MAX_WIDTH_DEF)) + 3) & ~32'd3;
        count = $urandom_range(4, 1) * pitch;
        // Now and then a broken row tail is left for the next settings.
        if ($urandom_range(3) == 0)
            count += $urandom_range(pitch + 2, 1);
        // Ending the image: one row, then bytes that must be dropped.
        if (h <= rows_done + 1)
            count = pitch + 3;
        repeat (count)
        begin
            if ($urandom_range(99) < 15)
                send_palette(8'($urandom), 24'($urandom));
            send_byte(8'($urandom));
        end
        drain(DRAIN_CYCLES);
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        while (live_items < 500)
            random_phase();
        idle_pct = 16;
    endtask

    task automatic test_random_stream();
        while (live_items < STREAM_GOAL)
            random_phase();
    endtask

    initial
    begin
        foreach (pal_rgb[i])
            pal_rgb[i] = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_state();
        test_indexed_modes();
        test_direct_modes();
        test_wide_row();
        test_back_to_back();
        test_random_stream();
        drain(20);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
sv/bpr_pkg.sv
sv/bpr_palette.sv
sv/bpr_decode.sv
sv/bpr_out.sv
sv/bmp_pixel_row_to_rgb.sv
tb/testbench.sv
